// ===== rtl/core/sha256_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants and initial hash values of the byte hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam logic OP_ABSORB   = 1'b0;
   localparam logic OP_FINALIZE = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // Request from the controller to the round engine.
   typedef struct packed {
      logic start;
      logic reinit;
   } eng_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } eng_sts_type;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sha256_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 round engine
// Owns the message schedule memory and runs 64 rounds, one per cycle, on the
// hash state. Message words are written by the controller, the last one in the same cycle as start.
// ----------------------------------------------------------------------------
module sha256_engine (
   input  wire                    clock,
   input  wire                    reset,
   input  wire sha256_pkg::eng_ctl_type ctl,
   input  wire                    wr_en,
   input  wire [3:0]              wr_addr,
   input  wire [31:0]             wr_data,
   input  wire [2:0]              hash_sel,
   output logic [31:0]            hash_word,
   output sha256_pkg::eng_sts_type sts
);

   // The schedule is kept as a 16-word sliding window in flip-flops, since
   // each round needs four taps of it at once.
   logic [31:0] sched_ff [16];
   logic [31:0] hash_ff  [8];
   logic [31:0] v_ff     [8];
   logic [6:0]  round_ff;
   logic        run_ff;
   logic        done_ff;

   logic [31:0] w_cur, s0, s1, t1, t2, e, a, w_new;
   logic [5:0]  r;
   logic [3:0]  tap15, tap2, tap7;

   assign r     = round_ff[5:0];
   assign tap15 = r[3:0] + 4'd1;
   assign tap2  = r[3:0] + 4'd14;
   assign tap7  = r[3:0] + 4'd9;

   always_comb begin
      a  = v_ff[0];
      e  = v_ff[4];
      s0 = sha256_pkg::ror32(sched_ff[tap15], 7)
         ^ sha256_pkg::ror32(sched_ff[tap15], 18)
         ^ (sched_ff[tap15] >> 3);
      s1 = sha256_pkg::ror32(sched_ff[tap2], 17)
         ^ sha256_pkg::ror32(sched_ff[tap2], 19)
         ^ (sched_ff[tap2] >> 10);
      w_new = s1 + sched_ff[tap7] + s0 + sched_ff[r[3:0]];
      w_cur = (round_ff < 7'd16) ? sched_ff[r[3:0]] : w_new;
      t1 = v_ff[7] + (sha256_pkg::ror32(e, 6) ^ sha256_pkg::ror32(e, 11)
         ^ sha256_pkg::ror32(e, 25)) + ((e & v_ff[5]) ^ (~e & v_ff[6]))
         + sha256_pkg::ROUND_K[r] + w_cur;
      t2 = (sha256_pkg::ror32(a, 2) ^ sha256_pkg::ror32(a, 13)
         ^ sha256_pkg::ror32(a, 22))
         + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sched_ff[wr_addr] <= wr_data;
      end else if (run_ff && round_ff < 7'd64) begin
         sched_ff[r[3:0]] <= w_cur;
      end
      if (reset || ctl.reinit) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= sha256_pkg::INIT_HASH[i];
      end else if (run_ff && round_ff == 7'd64) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + v_ff[i];
      end
      if (ctl.start) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= hash_ff[i];
      end else if (run_ff && round_ff < 7'd64) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            run_ff   <= 1'b1;
            round_ff <= '0;
         end else if (run_ff) begin
            if (round_ff == 7'd64) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               round_ff <= round_ff + 7'd1;
            end
         end
      end
   end

   assign hash_word = hash_ff[hash_sel];
   assign sts.busy  = run_ff;
   assign sts.done  = done_ff;

endmodule
`default_nettype wire

// ===== rtl/core/sha256_byte_stream_hasher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Absorb: a byte is taken whenever the hasher is absorbing; the 64th byte of a
// block then stalls the input while the round engine runs one round per cycle.
// Finalize: for each of one or two padded blocks, the padding pass steps
// through the sixteen schedule words and the rounds run; then eight digest
// words follow, one per cycle when the output is not stalled.
// Synchronous active-high reset loads the initial hash and empties the block.
// ----------------------------------------------------------------------------
// SHA-256 byte-stream hasher
// Packs bytes into schedule words, pads on finalize and streams the digest.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire sha256_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output sha256_pkg::rsp_type   rsp_data
);

   typedef enum logic [2:0] {
      ST_ABSORB, ST_WAIT, ST_PAD, ST_PADWAIT, ST_EMIT
   } state_type;

   state_type   state_ff;
   logic [5:0]  fill_ff;
   logic [63:0] bits_ff;
   logic [63:0] total_ff;
   logic [23:0] part_ff;
   logic        second_ff;   // finalize is on its extra second padding block
   logic [3:0]  pad_addr_ff;
   logic [2:0]  idx_ff;
   logic        rsp_valid_ff;

   sha256_pkg::eng_ctl_type ctl;
   sha256_pkg::eng_sts_type sts;
   logic        wr_en;
   logic [3:0]  wr_addr;
   logic [31:0] wr_data, pad_word, hash_word;
   logic        accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_ABSORB);

   // Padding word for the current position of the padding pass.
   always_comb begin
      logic [31:0] mk;
      logic [5:0]  base;
      base = {pad_addr_ff, 2'b00};
      mk   = '0;
      for (int k = 0; k < 4; k++) begin
         if (!second_ff && base + 6'(k) < fill_ff) begin
            mk[31-8*k -: 8] = (k == 0) ? part_ff[23:16] :
                              (k == 1) ? part_ff[15:8] : part_ff[7:0];
         end else if (!second_ff && base + 6'(k) == fill_ff) begin
            mk[31-8*k -: 8] = 8'h80;
         end
      end
      if (second_ff || fill_ff < 6'd56) begin
         if (pad_addr_ff == 4'd14) mk = total_ff[63:32];
         if (pad_addr_ff == 4'd15) mk = total_ff[31:0];
      end
      pad_word = mk;
   end

   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = pad_addr_ff;
      wr_data    = pad_word;
      ctl.start  = 1'b0;
      ctl.reinit = 1'b0;
      if (state_ff == ST_ABSORB && accept
          && req_data.opcode == sha256_pkg::OP_ABSORB && fill_ff[1:0] == 2'd3) begin
         wr_en   = 1'b1;
         wr_addr = fill_ff[5:2];
         wr_data = {part_ff, req_data.data_byte};
         ctl.start = (fill_ff == 6'd63);
      end
      if (state_ff == ST_PAD) begin
         // Complete message words already in the schedule are left alone.
         wr_en     = second_ff || (pad_addr_ff >= fill_ff[5:2]);
         ctl.start = (pad_addr_ff == 4'd15);
      end
      if (state_ff == ST_EMIT && idx_ff == 3'd7 && rsp_valid_ff && !rsp_stall)
         ctl.reinit = 1'b1;
   end

   sha256_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .hash_sel  (idx_ff),
      .hash_word (hash_word),
      .sts       (sts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ABSORB;
         fill_ff      <= '0;
         bits_ff      <= '0;
         second_ff    <= 1'b0;
         pad_addr_ff  <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_ABSORB: begin
               if (accept) begin
                  if (req_data.opcode == sha256_pkg::OP_ABSORB) begin
                     case (fill_ff[1:0])
                        2'd0: part_ff[23:16] <= req_data.data_byte;
                        2'd1: part_ff[15:8]  <= req_data.data_byte;
                        2'd2: part_ff[7:0]   <= req_data.data_byte;
                        default: ;
                     endcase
                     fill_ff <= fill_ff + 6'd1;
                     if (fill_ff == 6'd63) begin
                        bits_ff  <= bits_ff + 64'd512;
                        state_ff <= ST_WAIT;
                     end
                  end else begin
                     total_ff    <= bits_ff + {55'd0, fill_ff, 3'b000};
                     second_ff   <= 1'b0;
                     pad_addr_ff <= '0;
                     state_ff    <= ST_PAD;
                  end
               end
            end
            ST_WAIT: begin
               if (sts.done) state_ff <= ST_ABSORB;
            end
            ST_PAD: begin
               pad_addr_ff <= pad_addr_ff + 4'd1;
               if (pad_addr_ff == 4'd15) state_ff <= ST_PADWAIT;
            end
            ST_PADWAIT: begin
               if (sts.done) begin
                  if (!second_ff && fill_ff >= 6'd56) begin
                     second_ff   <= 1'b1;
                     pad_addr_ff <= '0;
                     state_ff    <= ST_PAD;
                  end else begin
                     idx_ff       <= '0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_EMIT;
                  end
               end
            end
            ST_EMIT: begin
               if (!rsp_stall) begin
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == 3'd7) begin
                     rsp_valid_ff <= 1'b0;
                     fill_ff      <= '0;
                     bits_ff      <= '0;
                     state_ff     <= ST_ABSORB;
                  end
               end
            end
            default: state_ff <= ST_ABSORB;
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.digest_word  = hash_word;
   assign rsp_data.word_index   = idx_ff;
   assign rsp_data.last_word    = (idx_ff == 3'd7);

endmodule
`default_nettype wire
